/* rtl/rvx_pkg.sv */
// Package with shared constants, opcodes and types of the RV32 execute block.
package rvx_pkg;

  localparam int XLEN       = 32;
  localparam int REG_AW     = 5;
  localparam int REG_DEPTH  = 1 << REG_AW;
  localparam int DMEM_WORDS = 4096;
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);
  localparam int DIV_CW     = $clog2(XLEN);

  localparam logic [XLEN-1:0]   EBREAK_WORD = 32'h0010_0073;
  localparam logic [XLEN-1:0]   JALR_MASK   = 32'hFFFF_FFFE;
  localparam logic [REG_AW-1:0] REG_A0      = 5'd10;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_EBREAK  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] SZ_NONE = 2'd0;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RS1,
    S_RS2,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_MEM0,
    S_MEM1,
    S_MEM2,
    S_WR1,
    S_DONE
  } state_t;

endpackage

/* rtl/rvx_div.sv */
// Iterative restoring divider for unsigned operands, one quotient bit per cycle.
module rvx_div
  import rvx_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [XLEN-1:0] dividend,
  input  logic [XLEN-1:0] divisor,
  output logic            done,
  output logic [XLEN-1:0] quotient,
  output logic [XLEN-1:0] remainder
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [XLEN-1:0]   dvs;
  logic [XLEN:0]     shifted;
  logic [XLEN+1:0]   diff;

  assign shifted = {remainder, quotient[XLEN-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == DIV_CW'(XLEN - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(XLEN - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!diff[XLEN+1]) begin
        remainder <= diff[XLEN-1:0];
        quotient  <= {quotient[XLEN-2:0], 1'b1};
      end else begin
        remainder <= shifted[XLEN-1:0];
        quotient  <= {quotient[XLEN-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/rv32im_subset_execute_top.sv */
// Top level of the RV32IM subset execute block with register file and data memory.
//
// One request on the input channel carries one instruction word, which is executed
// at the current pc. Every request gives exactly one result on the output channel
// with the pc, the next pc, the register write, any store and a status.
// cfg_write_en with cfg_write_data loads the start address and the pc; it must be
// written only while the block is idle; the block itself does not enforce this.
// After reset the block sweeps the 4096-word data memory to zero, one word per
// cycle, with in_ready low until the sweep ends; the register file clears at once.
// A request goes through S_RS1 and S_RS2 for the operands and S_EXEC, then S_MUL for
// multiplies, S_DIV for divides, S_MEM0 to S_MEM2 for loads and stores (and S_WR1
// for stores), and S_DONE loads the result register. The operands come through the
// single read port of the register file, memory accesses read two words and write
// back through one memory port, and the divider retires one bit a cycle. A result
// waits in the output register while out_ready is low; the block still takes the
// next request, then holds in its final state until the output register is free.
module rv32im_subset_execute_top
  import rvx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] inst_address,
  output logic [31:0] next_address,
  output logic        reg_written,
  output logic [4:0]  dest_index,
  output logic [31:0] dest_value,
  output logic [1:0]  store_size,
  output logic [31:0] store_address,
  output logic [31:0] store_value,
  output logic [1:0]  status,
  output logic [31:0] exit_code
);

  state_t state, state_next;

  logic [XLEN-1:0] pc;
  logic [XLEN-1:0] ins;
  logic [XLEN-1:0] opa, opb;

  logic [XLEN-1:0]   rf [REG_DEPTH];
  logic [REG_DEPTH-1:0] rf_vld;
  logic [REG_AW-1:0] rf_raddr;
  logic [XLEN-1:0]   rf_rdata;
  logic              rf_rok;
  logic [XLEN-1:0]   rf_val;
  logic              rf_we;

  logic [XLEN-1:0]    dmem [DMEM_WORDS];
  logic [DMEM_AW-1:0] clr_cnt;
  logic [DMEM_AW-1:0] dm_raddr, dm_waddr;
  logic [XLEN-1:0]    dm_rdata, dm_wdata;
  logic               dm_we;
  logic [XLEN-1:0]    w0, w_hi;

  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [REG_AW-1:0] rd;
  logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [XLEN-1:0] x_val, x_next, x_ea;
  logic x_wr, x_bad, x_load, x_store, x_mul, x_div, x_take, x_slt;

  logic [XLEN-1:0] r_val, r_next, r_ea;
  logic r_wr, r_bad, r_load, r_store, r_mul;

  logic signed [2*XLEN+1:0] prod;

  logic            div_start, div_done, div_signed;
  logic [XLEN-1:0] div_q, div_r, div_a, div_b, div_val;
  logic            div_rem;

  logic [1:0]   off;
  logic [63:0]  win, win_sh, mask64, data64, win_new;
  logic [7:0]   bmask;
  logic [XLEN-1:0] ld_val;

  logic            fin_ebreak, fin_wr, fin_store;
  logic [XLEN-1:0] fin_val, fin_next;
  logic            out_free;

  assign op = ins[6:0];
  assign f3 = ins[14:12];
  assign f7 = ins[31:25];
  assign rd = ins[11:7];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'b0};

  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (&clr_cnt) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_RS1;
      S_RS1:   state_next = S_RS2;
      S_RS2:   state_next = S_EXEC;
      S_EXEC: begin
        if (x_mul) state_next = S_MUL;
        else if (x_div) state_next = S_DIV;
        else if (x_load || x_store) state_next = S_MEM0;
        else state_next = S_DONE;
      end
      S_MUL:  state_next = S_DONE;
      S_DIV:  if (div_done) state_next = S_DONE;
      S_MEM0: state_next = S_MEM1;
      S_MEM1: state_next = S_MEM2;
      S_MEM2: state_next = r_store ? S_WR1 : S_DONE;
      S_WR1:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    dm_we     = 1'b0;
    dm_waddr  = r_ea[DMEM_AW+1:2];
    dm_wdata  = win_new[31:0];
    dm_raddr  = r_ea[DMEM_AW+1:2];
    rf_we     = 1'b0;
    rf_raddr  = ins[24:20];
    case (state)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_cnt;
        dm_wdata = '0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        rf_raddr = (instruction == EBREAK_WORD) ? REG_A0 : instruction[19:15];
      end
      S_EXEC:  div_start = x_div;
      S_MEM1:  dm_raddr = r_ea[DMEM_AW+1:2] + 1'b1;
      S_MEM2:  dm_we = r_store;
      S_WR1: begin
        dm_we    = 1'b1;
        dm_waddr = r_ea[DMEM_AW+1:2] + 1'b1;
        dm_wdata = w_hi;
      end
      S_DONE:  rf_we = out_free && fin_wr;
      default: ;
    endcase
  end

  // Decode and execute.
  always_comb begin
    x_val   = '0;
    x_next  = pc + 32'd4;
    x_ea    = opa + imm_i;
    x_wr    = 1'b0;
    x_bad   = 1'b0;
    x_load  = 1'b0;
    x_store = 1'b0;
    x_mul   = 1'b0;
    x_div   = 1'b0;
    x_take  = 1'b0;
    x_slt   = $signed(opa) < $signed(opb);
    case (op)
      OP_LUI: begin
        x_wr  = 1'b1;
        x_val = imm_u;
      end
      OP_AUIPC: begin
        x_wr  = 1'b1;
        x_val = pc + imm_u;
      end
      OP_JAL: begin
        x_wr   = 1'b1;
        x_val  = pc + 32'd4;
        x_next = pc + imm_j;
      end
      OP_JALR: begin
        x_bad  = (f3 != 3'd0);
        x_wr   = 1'b1;
        x_val  = pc + 32'd4;
        x_next = (opa + imm_i) & JALR_MASK;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: x_take = (opa == opb);
          3'd1: x_take = (opa != opb);
          3'd4: x_take = x_slt;
          3'd5: x_take = !x_slt;
          3'd6: x_take = (opa < opb);
          3'd7: x_take = (opa >= opb);
          default: x_bad = 1'b1;
        endcase
        if (x_take) x_next = pc + imm_b;
      end
      OP_LOAD: begin
        x_wr   = 1'b1;
        x_load = 1'b1;
        x_bad  = !(f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5);
      end
      OP_STORE: begin
        x_store = 1'b1;
        x_ea    = opa + imm_s;
        x_bad   = (f3 > 3'd2);
      end
      OP_IMM: begin
        x_wr = 1'b1;
        case (f3)
          3'd0: x_val = opa + imm_i;
          3'd3: x_val = {31'b0, opa < imm_i};
          3'd4: x_val = opa ^ imm_i;
          3'd6: x_val = opa | imm_i;
          3'd7: x_val = opa & imm_i;
          3'd1: begin
            x_val = opa << ins[24:20];
            x_bad = (f7 != F7_BASE);
          end
          3'd5: begin
            if (f7 == F7_BASE) x_val = opa >> ins[24:20];
            else if (f7 == F7_ALT) x_val = XLEN'($signed(opa) >>> ins[24:20]);
            else x_bad = 1'b1;
          end
          default: x_bad = 1'b1;
        endcase
      end
      OP_REG: begin
        x_wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: x_val = opa + opb;
            3'd1: x_val = opa << opb[4:0];
            3'd2: x_val = {31'b0, x_slt};
            3'd3: x_val = {31'b0, opa < opb};
            3'd4: x_val = opa ^ opb;
            3'd5: x_val = opa >> opb[4:0];
            3'd6: x_val = opa | opb;
            default: x_val = opa & opb;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          x_val = opa - opb;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          x_val = XLEN'($signed(opa) >>> opb[4:0]);
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0, 3'd1: x_mul = 1'b1;
            3'd4, 3'd5, 3'd6, 3'd7: x_div = 1'b1;
            default: x_bad = 1'b1;
          endcase
        end else begin
          x_bad = 1'b1;
        end
      end
      default: x_bad = (ins != EBREAK_WORD);
    endcase
    if (x_bad) begin
      x_mul   = 1'b0;
      x_div   = 1'b0;
      x_load  = 1'b0;
      x_store = 1'b0;
    end
  end

  assign div_signed = !f3[0];
  assign div_rem    = f3[1];
  assign div_a = (div_signed && opa[31]) ? (32'd0 - opa) : opa;
  assign div_b = (div_signed && opb[31]) ? (32'd0 - opb) : opb;

  rvx_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    if (opb == '0) begin
      div_val = div_rem ? opa : '1;
    end else if (div_rem) begin
      div_val = (div_signed && opa[31]) ? (32'd0 - div_r) : div_r;
    end else begin
      div_val = (div_signed && (opa[31] ^ opb[31])) ? (32'd0 - div_q) : div_q;
    end
  end

  // Byte window over two consecutive words for loads and stores.
  assign off    = r_ea[1:0];
  assign win    = {dm_rdata, w0};
  assign win_sh = win >> {off, 3'b000};
  assign bmask  = (f3[1:0] == 2'd0) ? 8'h01 : (f3[1:0] == 2'd1) ? 8'h03 : 8'h0F;
  assign data64 = {32'b0, opb} << {off, 3'b000};

  always_comb begin
    logic [7:0] bm;
    bm = bmask << off;
    for (int k = 0; k < 8; k++) begin
      mask64[8*k +: 8] = {8{bm[k]}};
    end
  end

  assign win_new = (win & ~mask64) | (data64 & mask64);

  always_comb begin
    case (f3)
      3'd1:    ld_val = {{16{win_sh[15]}}, win_sh[15:0]};
      3'd2:    ld_val = win_sh[31:0];
      3'd4:    ld_val = {24'b0, win_sh[7:0]};
      default: ld_val = {16'b0, win_sh[15:0]};
    endcase
  end

  assign fin_ebreak = (ins == EBREAK_WORD);
  assign fin_wr     = r_wr && !r_bad && (rd != '0);
  assign fin_store  = r_store && !r_bad;
  assign fin_next   = r_bad ? (pc + 32'd4) : r_next;
  assign fin_val    = !r_mul ? r_val : (f3[0] ? prod[2*XLEN-1:XLEN] : prod[XLEN-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      pc      <= '0;
      rf_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        pc <= cfg_write_data;
      end else if (state == S_DONE && out_free) begin
        pc <= fin_next;
      end
      if (rf_we) rf_vld[rd] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rf_rdata <= rf[rf_raddr];
    rf_rok   <= rf_vld[rf_raddr];
    if (rf_we) rf[rd] <= fin_val;
  end

  assign rf_val = rf_rok ? rf_rdata : '0;

  always_ff @(posedge clk) begin
    dm_rdata <= dmem[dm_raddr];
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) ins <= instruction;
      S_RS1:  opa <= rf_val;
      S_RS2:  opb <= rf_val;
      S_EXEC: begin
        r_val   <= x_val;
        r_next  <= x_next;
        r_ea    <= x_ea;
        r_wr    <= x_wr;
        r_bad   <= x_bad;
        r_load  <= x_load;
        r_store <= x_store;
        r_mul   <= x_mul;
      end
      S_MUL:  prod <= $signed({opa[31], opa}) * $signed({opb[31], opb});
      S_DIV:  if (div_done) r_val <= div_val;
      S_MEM1: w0 <= dm_rdata;
      S_MEM2: begin
        w_hi <= win_new[63:32];
        if (r_load) r_val <= ld_val;
      end
      S_DONE: begin
        if (out_free) begin
          inst_address  <= pc;
          next_address  <= fin_next;
          reg_written   <= fin_wr;
          dest_index    <= fin_wr ? rd : '0;
          dest_value    <= fin_wr ? fin_val : '0;
          store_size    <= fin_store ? (f3[1:0] + 2'd1) : SZ_NONE;
          store_address <= fin_store ? r_ea : '0;
          store_value   <= fin_store ? opb : '0;
          status        <= r_bad ? ST_INVALID : (fin_ebreak ? ST_EBREAK : ST_NORMAL);
          exit_code     <= (!r_bad && fin_ebreak) ? opa : '0;
        end
      end
      default: ;
    endcase
  end

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("A second request was taken while one is in flight.");

  a_x0_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_written |-> dest_index != '0)
    else $error("A write to x0 was reported.");

  a_trap_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_NORMAL |-> !reg_written && store_size == SZ_NONE)
    else $error("A trapping request wrote a register or memory.");

  a_invalid_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_INVALID |-> next_address == inst_address + 32'd4)
    else $error("An invalid request did not advance the pc by four.");

endmodule

/* tb/rv32im_exec_checker.sv */
// Checker that predicts the execute results from accepted requests and compares them.
module rv32im_exec_checker
  import rvx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] instruction,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] inst_address,
  input  logic [31:0] next_address,
  input  logic        reg_written,
  input  logic [4:0]  dest_index,
  input  logic [31:0] dest_value,
  input  logic [1:0]  store_size,
  input  logic [31:0] store_address,
  input  logic [31:0] store_value,
  input  logic [1:0]  status,
  input  logic [31:0] exit_code,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [1:0]  ssize;
    logic [31:0] saddr;
    logic [31:0] sval;
    logic [1:0]  st;
    logic [31:0] code;
  } exec_result_t;

  exec_result_t retire_q[$];
  logic [31:0]  pc_q;
  logic [31:0]  regs[32];
  logic [7:0]   mem_bytes[DMEM_WORDS*4];

  function automatic logic [31:0] mem_rd(logic [31:0] addr, int n);
    logic [31:0] v;
    v = 0;
    for (int k = 0; k < n; k++)
      v |= 32'(mem_bytes[(addr + k) % (DMEM_WORDS * 4)]) << (8 * k);
    return v;
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit want_rem);
    logic [31:0] ma, mb, q, r;
    if (b == 0) return want_rem ? a : 32'hFFFF_FFFF;
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return want_rem ? 32'h0 : a;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (a[31] ^ b[31]) q = -q;
    if (a[31]) r = -r;
    return want_rem ? r : q;
  endfunction

  task automatic execute_insn(logic [31:0] ins);
    exec_result_t e;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, ea, half;
    logic [63:0] prod;
    bit bad, take;
    op = ins[6:0];
    f3 = ins[14:12];
    f7 = ins[31:25];
    a = regs[ins[19:15]];
    b = regs[ins[24:20]];
    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
    e = '0;
    e.pc = pc_q;
    e.npc = pc_q + 4;
    e.rd = ins[11:7];
    e.st = ST_NORMAL;
    bad = 0;
    take = 0;
    case (op)
      OP_LUI: begin e.wr = 1; e.val = {ins[31:12], 12'h0}; end
      OP_AUIPC: begin e.wr = 1; e.val = pc_q + {ins[31:12], 12'h0}; end
      OP_JAL: begin e.wr = 1; e.val = pc_q + 4; e.npc = pc_q + imm_j; end
      OP_JALR: begin
        if (f3 != 0) bad = 1;
        else begin
          e.wr = 1; e.val = pc_q + 4; e.npc = (a + imm_i) & JALR_MASK;
        end
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = $signed(a) >= $signed(b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: bad = 1;
        endcase
        if (take) e.npc = pc_q + imm_b;
      end
      OP_LOAD: begin
        ea = a + imm_i;
        e.wr = 1;
        case (f3)
          3'd1: begin
            half = mem_rd(ea, 2);
            e.val = {{16{half[15]}}, half[15:0]};
          end
          3'd2: e.val = mem_rd(ea, 4);
          3'd4: e.val = mem_rd(ea, 1);
          3'd5: e.val = mem_rd(ea, 2);
          default: bad = 1;
        endcase
      end
      OP_STORE: begin
        if (f3 > 2) bad = 1;
        else begin
          e.ssize = f3[1:0] + 2'd1;
          e.saddr = a + imm_s;
          e.sval = b;
          for (int k = 0; k < (f3 == 2 ? 4 : f3 + 1); k++)
            mem_bytes[(e.saddr + k) % (DMEM_WORDS * 4)] = b[8*k +: 8];
        end
      end
      OP_IMM: begin
        e.wr = 1;
        case (f3)
          3'd0: e.val = a + imm_i;
          3'd3: e.val = {31'h0, a < imm_i};
          3'd4: e.val = a ^ imm_i;
          3'd6: e.val = a | imm_i;
          3'd7: e.val = a & imm_i;
          3'd1: if (f7 == F7_BASE) e.val = a << imm_i[4:0]; else bad = 1;
          3'd5: begin
            if (f7 == F7_BASE) e.val = a >> imm_i[4:0];
            else if (f7 == F7_ALT) e.val = $signed(a) >>> imm_i[4:0];
            else bad = 1;
          end
          default: bad = 1;
        endcase
      end
      OP_REG: begin
        e.wr = 1;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: e.val = a + b;
            3'd1: e.val = a << b[4:0];
            3'd2: e.val = {31'h0, $signed(a) < $signed(b)};
            3'd3: e.val = {31'h0, a < b};
            3'd4: e.val = a ^ b;
            3'd5: e.val = a >> b[4:0];
            3'd6: e.val = a | b;
            default: e.val = a & b;
          endcase
        end else if (f7 == F7_ALT && f3 == 0) e.val = a - b;
        else if (f7 == F7_ALT && f3 == 5) e.val = $signed(a) >>> b[4:0];
        else if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0: e.val = a * b;
            3'd1: begin
              prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              e.val = prod[63:32];
            end
            3'd4: e.val = sdiv(a, b, 0);
            3'd5: e.val = b != 0 ? a / b : 32'hFFFF_FFFF;
            3'd6: e.val = sdiv(a, b, 1);
            3'd7: e.val = b != 0 ? a % b : a;
            default: bad = 1;
          endcase
        end else bad = 1;
      end
      default: begin
        if (ins == EBREAK_WORD) begin e.st = ST_EBREAK; e.code = regs[REG_A0]; end
        else bad = 1;
      end
    endcase
    if (bad) begin
      e.wr = 0; e.val = 0; e.npc = pc_q + 4; e.st = ST_INVALID;
    end
    if (!e.wr || e.rd == 0) begin
      e.wr = 0; e.rd = 0; e.val = 0;
    end else regs[e.rd] = e.val;
    pc_q = e.npc;
    retire_q.push_back(e);
  endtask

  always @(posedge clk) begin
    exec_result_t got, want;
    if (rst) begin
      pc_q = 0;
      foreach (regs[i]) regs[i] = 0;
      foreach (mem_bytes[i]) mem_bytes[i] = 0;
    end else begin
      if (cfg_write_en) pc_q = cfg_write_data;
      if (out_valid && out_ready) begin
        got = {inst_address, next_address, reg_written, dest_index, dest_value,
               store_size, store_address, store_value, status, exit_code};
        results_seen++;
        if (retire_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result: %h", got);
        end else begin
          want = retire_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch at pc %h:\n  expected %h\n  actual   %h",
                       want.pc, want, got);
          end
        end
      end
      if (in_valid && in_ready) execute_insn(instruction);
    end
    pending = retire_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
  end

endmodule

/* tb/tb_top.sv */
// Testbench top that drives instruction requests and start addresses and gives the verdict.
module tb_top;
  import rvx_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_write_en = 0;
  logic [31:0] cfg_write_data = 0;
  logic in_valid = 0, out_ready = 0;
  logic [31:0] instruction = 0;
  logic in_ready, out_valid, reg_written;
  logic [31:0] inst_address, next_address, dest_value, store_address, store_value, exit_code;
  logic [4:0] dest_index;
  logic [1:0] store_size, status;
  int fail_count, pending, results_seen;
  int idle_cycles = 0, sent = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  rv32im_subset_execute_top dut (.*);
  rv32im_exec_checker chk (.*);

  // Watchdog: its limit covers the memory clear after reset.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("** rv32im_subset_execute_top: FAILED **");
      $finish;
    end
  end

  // The receiver stalls in phases of random density.
  always @(posedge clk) begin
    if (sent < 60) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0) || (sent % 200 < 40);
  end

  function automatic logic [4:0] rreg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
  endfunction

  function automatic logic [31:0] rand_insn();
    logic [31:0] w;
    logic [4:0] rd, r1, r2;
    logic [11:0] off;
    rd = rreg(); r1 = rreg(); r2 = rreg();
    w = $urandom;
    off = ($urandom_range(0, 1)) ? 12'($urandom_range(0, 63)) : 12'($urandom);
    case ($urandom_range(0, 13))
      0: return {w[31:12], rd, OP_LUI};
      1: return {w[31:12], rd, OP_AUIPC};
      2: return {w[31:12], rd, OP_JAL};
      3: return {w[31:20], r1, 3'd0, rd, OP_JALR};
      4: return {w[31:25], r2, r1, w[14:12], w[11:7], OP_BRANCH};
      5: return {off, r1, w[14:12], rd, OP_LOAD};
      6: return {off[11:5], r2, r1, 1'b0, w[13:12], off[4:0], OP_STORE};
      7, 8: return {w[31:20], r1, w[14:12], rd, OP_IMM};
      9: return {(w[0] ? F7_ALT : F7_BASE), r2, r1, w[14:12], rd, OP_REG};
      10, 11: return {F7_MULDIV, r2, r1, w[14:12], rd, OP_REG};
      12: return ($urandom_range(0, 1)) ? EBREAK_WORD : w;
      default: return {w[31:25], r2, r1, w[14:12], rd, w[0] ? OP_IMM : OP_REG};
    endcase
  endfunction

  task automatic send(logic [31:0] ins);
    in_valid <= 1;
    instruction <= ins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_start(logic [31:0] addr);
    drain();
    cfg_write_en <= 1;
    cfg_write_data <= addr;
    @(posedge clk);
    cfg_write_en <= 0;
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        send(rand_insn());
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    // Directed: register setup, every operation class but AUIPC, and the corner cases.
    send({20'h80000, 5'd1, OP_LUI});                         // x1 = 0x80000000
    send({12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM});               // x2 = -1
    send({12'h7FF, 5'd0, 3'd0, 5'd10, OP_IMM});              // a0
    send({F7_MULDIV, 5'd2, 5'd1, 3'd4, 5'd3, OP_REG});       // div overflow
    send({F7_MULDIV, 5'd2, 5'd1, 3'd6, 5'd4, OP_REG});       // rem overflow
    send({F7_MULDIV, 5'd0, 5'd1, 3'd4, 5'd5, OP_REG});       // div by zero
    send({F7_MULDIV, 5'd0, 5'd1, 3'd7, 5'd6, OP_REG});       // remu by zero
    send({F7_MULDIV, 5'd2, 5'd1, 3'd1, 5'd7, OP_REG});       // mulh
    send({F7_BASE, 5'd2, 5'd1, 3'd5, 5'd8, OP_REG});         // shift by 31
    send({F7_ALT, 5'd2, 5'd1, 3'd5, 5'd9, OP_REG});          // sra
    send({7'h7F, 5'd2, 5'd0, 3'd2, 5'h1F, OP_STORE});        // sw at -1, wraps
    send({12'hFFF, 5'd0, 3'd2, 5'd11, OP_LOAD});             // misaligned lw
    send({12'hFFE, 5'd0, 3'd1, 5'd12, OP_LOAD});             // lh
    send({12'h001, 5'd0, 3'd5, 5'd0, OP_LOAD});              // write to x0
    send({20'hFFFFF, 5'd1, OP_LUI});                         // lui x1
    send({12'h003, 5'd2, 3'd0, 5'd13, OP_JALR});             // jalr, target x2 + 3
    send({7'h7F, 5'd1, 5'd1, 3'd0, 5'h1F, OP_BRANCH});       // beq taken back
    send({20'hFFFFF, 5'd14, OP_JAL});
    send(EBREAK_WORD);
    send({12'h000, 5'd1, 3'd0, 5'd1, OP_LOAD});              // lb: invalid
    send({F7_ALT, 5'd1, 5'd1, 3'd5, 5'd1, OP_IMM} | 32'h02000000);
    send(32'hFFFF_FFFF);
    send(32'h0000_0000);
    set_start(32'hFFFF_FFFC);
    random_phase(300);
    set_start(32'h0000_0000);
    random_phase(300);
    set_start($urandom);
    random_phase(380);
    drain();
    $display("Ran %0d instruction requests over four start addresses; %0d results checked.",
             sent, results_seen);
    if (fail_count == 0) $display("** rv32im_subset_execute_top: PASSED **");
    else $display("** rv32im_subset_execute_top: FAILED **");
    $finish;
  end

endmodule

/* rv32im_subset_execute_top.f */
rtl/rvx_pkg.sv
rtl/rvx_div.sv
rtl/rv32im_subset_execute_top.sv
tb/rv32im_exec_checker.sv
tb/tb_top.sv
